// ----- rtl/itoa_pkg.sv -----
`timescale 1ns / 1ps
// itoa_pkg: shared types, constants, digit encoding and the control store
// for the integer to ascii converter; no dependencies

package itoa_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int RADIX_WIDTH = 6;
  localparam int SYM_WIDTH   = 8;
  localparam int MIN_RADIX   = 2;
  localparam int MAX_RADIX   = 35;
  localparam logic [SYM_WIDTH-1:0] MINUS_CHAR = 8'h2d;
  localparam logic [SYM_WIDTH-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [SYM_WIDTH-1:0] ALPHA_CHAR = 8'h61;

  localparam int PC_WIDTH = 3;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0]        radix;
  } itoa_in_t;

  typedef struct packed {
    logic [SYM_WIDTH-1:0] symbol;
    logic                 last;
    logic                 bad_base;
  } itoa_out_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CHECK,
    OP_BAD,
    OP_SIGN,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_PUSH,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [PC_WIDTH-1:0] target;
  } ctl_word_t;

  localparam logic [PC_WIDTH-1:0] PC_WAIT    = 3'd0;
  localparam logic [PC_WIDTH-1:0] PC_CHECK   = 3'd1;
  localparam logic [PC_WIDTH-1:0] PC_BAD     = 3'd2;
  localparam logic [PC_WIDTH-1:0] PC_SIGN    = 3'd3;
  localparam logic [PC_WIDTH-1:0] PC_DIVINIT = 3'd4;
  localparam logic [PC_WIDTH-1:0] PC_DIVSTEP = 3'd5;
  localparam logic [PC_WIDTH-1:0] PC_PUSH    = 3'd6;
  localparam logic [PC_WIDTH-1:0] PC_EMIT    = 3'd7;

  // control store: target is taken when the step's condition holds, else pc + 1
  function automatic ctl_word_t ucode(input logic [PC_WIDTH-1:0] pc);
    ctl_word_t cw;
    case (pc)
      PC_WAIT:    cw = '{op: OP_WAIT,    target: PC_WAIT};
      PC_CHECK:   cw = '{op: OP_CHECK,   target: PC_SIGN};
      PC_BAD:     cw = '{op: OP_BAD,     target: PC_WAIT};
      PC_SIGN:    cw = '{op: OP_SIGN,    target: PC_DIVINIT};
      PC_DIVINIT: cw = '{op: OP_DIVINIT, target: PC_DIVSTEP};
      PC_DIVSTEP: cw = '{op: OP_DIVSTEP, target: PC_DIVSTEP};
      PC_PUSH:    cw = '{op: OP_PUSH,    target: PC_DIVINIT};
      PC_EMIT:    cw = '{op: OP_EMIT,    target: PC_EMIT};
      default:    cw = '{op: OP_WAIT,    target: PC_WAIT};
    endcase
    return cw;
  endfunction

  function automatic logic [SYM_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
    logic [SYM_WIDTH-1:0] d_ext;
    d_ext = SYM_WIDTH'(d);
    if (d < RADIX_WIDTH'(10)) begin
      return ZERO_CHAR + d_ext;
    end else begin
      return ALPHA_CHAR + d_ext - SYM_WIDTH'(10);
    end
  endfunction

endpackage

// ----- rtl/integer_to_ascii_radix.sv -----
`timescale 1ns / 1ps
// integer_to_ascii_radix: signed integer to ascii digits in radix 2..35
// depends on itoa_pkg (types, control store, digit encoding)

// A word is taken when start is high and busy is low. Results come out one
// per out_valid strobe, most significant character first, a leading '-' for
// negative values, last set on the final one; the receiver cannot stall and
// must take each strobe. A radix outside 2..35 gives one result with bad_base
// and last set and symbol zero. Otherwise each digit of a conversion is one
// bit-serial restoring division by the radix, one quotient bit per cycle,
// run by a small control store sequencer. busy drops in the cycle the final
// strobe is shown.

module integer_to_ascii_radix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::itoa_in_t  in_data,
  output logic                out_valid,
  output itoa_pkg::itoa_out_t out_data
);

  localparam int VW   = itoa_pkg::VALUE_WIDTH;
  localparam int RW   = itoa_pkg::RADIX_WIDTH;
  localparam int PCW  = itoa_pkg::PC_WIDTH;
  localparam int CNTW = $clog2(VW);
  localparam int NDW  = $clog2(VW + 1);
  localparam int IDXW = $clog2(VW);

  logic [PCW-1:0]         pc_r, pc_nxt;
  itoa_pkg::ctl_word_t    cw;
  logic                   take;

  logic                   neg_r;
  logic [RW-1:0]          radix_r;
  logic [VW-1:0]          quo_r;
  logic [RW-1:0]          rem_r;
  logic [CNTW-1:0]        cnt_r;
  logic [NDW-1:0]         ndig_r;
  logic [RW-1:0]          stack_r [VW];
  logic                   out_valid_r;
  itoa_pkg::itoa_out_t    out_r;

  logic [VW-1:0]          raw;
  logic [RW:0]            shifted;
  logic                   ge;
  logic [RW:0]            diff;
  logic [NDW-1:0]         ndig_dec;
  logic                   radix_ok;

  assign cw       = itoa_pkg::ucode(pc_r);
  assign busy     = (cw.op != itoa_pkg::OP_WAIT);
  assign raw      = in_data.value[VW-1:0];
  assign shifted  = {rem_r, quo_r[VW-1]};
  assign diff     = shifted - {1'b0, radix_r};
  assign ge       = (shifted >= {1'b0, radix_r});
  assign ndig_dec = ndig_r - NDW'(1);
  assign radix_ok = (radix_r >= RW'(itoa_pkg::MIN_RADIX)) &&
                    (radix_r <= RW'(itoa_pkg::MAX_RADIX));

  // sequencer branch condition per micro-op
  always_comb begin
    case (cw.op)
      itoa_pkg::OP_WAIT:    take = !start;
      itoa_pkg::OP_CHECK:   take = radix_ok;
      itoa_pkg::OP_BAD:     take = 1'b1;
      itoa_pkg::OP_SIGN:    take = 1'b1;
      itoa_pkg::OP_DIVINIT: take = 1'b1;
      itoa_pkg::OP_DIVSTEP: take = (cnt_r != '0);
      itoa_pkg::OP_PUSH:    take = (quo_r != '0) &&
                                   (ndig_r + NDW'(1) < NDW'(VW));
      itoa_pkg::OP_EMIT:    take = (ndig_r != NDW'(1));
      default:              take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + PCW'(1);
  end

  // PUSH reuses the divider result of the final step, so quo_r is already final
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= itoa_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
      ndig_r      <= '0;
    end else begin
      pc_r        <= pc_nxt;
      case (cw.op)
        itoa_pkg::OP_WAIT: begin
          out_valid_r <= 1'b0;
          if (start) begin
            neg_r   <= raw[VW-1];
            quo_r   <= raw[VW-1] ? (~raw + VW'(1)) : raw;
            radix_r <= in_data.radix;
          end
        end
        itoa_pkg::OP_CHECK: begin
          out_valid_r <= 1'b0;
          ndig_r      <= '0;
        end
        itoa_pkg::OP_BAD: begin
          out_valid_r    <= 1'b1;
          out_r.symbol   <= '0;
          out_r.last     <= 1'b1;
          out_r.bad_base <= 1'b1;
        end
        itoa_pkg::OP_SIGN: begin
          out_valid_r    <= neg_r;
          out_r.symbol   <= itoa_pkg::MINUS_CHAR;
          out_r.last     <= 1'b0;
          out_r.bad_base <= 1'b0;
        end
        itoa_pkg::OP_DIVINIT: begin
          out_valid_r <= 1'b0;
          rem_r       <= '0;
          cnt_r       <= CNTW'(VW - 1);
        end
        itoa_pkg::OP_DIVSTEP: begin
          out_valid_r <= 1'b0;
          rem_r       <= ge ? diff[RW-1:0] : shifted[RW-1:0];
          quo_r       <= {quo_r[VW-2:0], ge};
          cnt_r       <= cnt_r - CNTW'(1);
        end
        itoa_pkg::OP_PUSH: begin
          out_valid_r               <= 1'b0;
          stack_r[ndig_r[IDXW-1:0]] <= rem_r;
          ndig_r                    <= ndig_r + NDW'(1);
        end
        itoa_pkg::OP_EMIT: begin
          out_valid_r    <= 1'b1;
          out_r.symbol   <= itoa_pkg::digit_char(stack_r[ndig_dec[IDXW-1:0]]);
          out_r.last     <= (ndig_r == NDW'(1));
          out_r.bad_base <= 1'b0;
          ndig_r         <= ndig_dec;
        end
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_base |-> out_data.last && out_data.symbol == '0)
    else $error("bad radix result not a lone zero final result");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result strobe right after final result");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("still busy when final result shown");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid && busy)
    else $error("result or idle right after accepting a word");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= NDW'(VW))
    else $error("digit count beyond value width");
`endif

endmodule
